[hw/rtl/min_ratio_spanning_tree_core_assert.svh]
// Assertion macros shared by the checker.
`ifndef MIN_RATIO_SPANNING_TREE_CORE_ASSERT_SVH
`define MIN_RATIO_SPANNING_TREE_CORE_ASSERT_SVH

// Same-cycle implication.
`define MRST_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MRST_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mrst_pkg.sv]
package mrst_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int RATE_W  = 40;
  localparam int ROUND_W = 8;
  localparam int TOL_W   = 16;
  localparam int CFG_W   = 16;
  localparam int STEP_W  = 7;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 71;

  localparam logic [RATE_W-1:0] RATE_ONE  = 40'h00_0001_0000;
  localparam logic [RATE_W-1:0] RATIO_MAX = 40'hFF_FFFF_FFFF;

  localparam logic REG_TOLERANCE  = 1'b0;
  localparam logic REG_ITER_LIMIT = 1'b1;

  typedef struct packed {
    logic             pt_wr;
    logic [IDX_W-1:0] wr_addr;
    logic             rd;
    logic             rd_pick;
    logic [IDX_W-1:0] rd_addr;
    logic             from_ld;
    logic             sq_mul;
    logic             sqrt_ld;
    logic             sqrt_step;
    logic             mul_w;
    logic             edge_fin;
    logic             init;
    logic             min_clr;
    logic             mark;
    logic             sums_clr;
    logic             sums_acc;
    logic             rate_one;
    logic             div_ld;
    logic             div_step;
    logic             rate_upd;
  } mrst_cmd_t;

  typedef struct packed {
    logic in_tree;
    logic conv;
  } mrst_sts_t;

endpackage

[hw/rtl/mrst_datapath.sv]
module mrst_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mrst_pkg::mrst_cmd_t           cmd,
  input  logic [15:0]                   in_x,
  input  logic [15:0]                   in_y,
  input  logic [23:0]                   in_h,
  input  logic [mrst_pkg::TOL_W-1:0]    tolerance,
  output mrst_pkg::mrst_sts_t           sts,
  output logic [mrst_pkg::RATE_W-1:0]   rate,
  output logic                          rate_sat
);

  // point store and Prim work store
  logic [55:0]  pt_mem  [mrst_pkg::MAX_POINTS];
  logic [120:0] key_mem [mrst_pkg::MAX_POINTS];

  logic [55:0]  pt_q_r;
  logic [120:0] key_q_r;
  logic [mrst_pkg::IDX_W-1:0] rd_idx_r;
  logic [mrst_pkg::IDX_W-1:0] raddr;

  logic [15:0] px_r, py_r;
  logic [23:0] ph_r;
  logic [31:0] sqx_r, sqy_r;
  logic [23:0] dh_r;

  logic [63:0] v_r;
  logic [34:0] rem_r;
  logic [31:0] root_r;
  logic [55:0] m_hi_r, m_lo_r;

  logic                       found_r;
  logic signed [63:0]         min_key_r;
  logic [31:0]                min_len_r;
  logic [23:0]                min_h_r;
  logic [mrst_pkg::IDX_W-1:0] pick_r;

  logic signed [63:0] sum_w_r;
  logic [47:0]        sum_l_r;
  logic [39:0]        sum_h_r;

  logic [70:0] dd_r, q_r;
  logic [48:0] drem_r;

  logic [mrst_pkg::RATE_W-1:0] rate_r;
  logic                        sat_r;

  logic [15:0] xq, yq, dx, dy;
  logic [23:0] hq;
  logic [34:0] srem, strial;
  logic [57:0] p;
  logic signed [63:0] w, key_q, new_key;
  logic        upd;
  logic [31:0] new_len;
  logic [23:0] new_h;
  logic [64:0] s65;
  logic [63:0] sat_sum, mag;
  logic [48:0] r2;

  assign raddr = cmd.rd_pick ? pick_r : cmd.rd_addr;
  assign xq    = pt_q_r[55:40];
  assign yq    = pt_q_r[39:24];
  assign hq    = pt_q_r[23:0];
  assign dx    = (px_r > xq) ? px_r - xq : xq - px_r;
  assign dy    = (py_r > yq) ? py_r - yq : yq - py_r;
  assign key_q = key_q_r[63:0];

  // one step of the restoring square root
  assign srem   = {rem_r[32:0], v_r[63:62]};
  assign strial = {1'b0, root_r, 2'b01};

  // edge weight and relaxation
  assign p       = {1'b0, m_hi_r, 1'b0} + {17'd0, m_lo_r[55:15]};
  assign w       = $signed({24'd0, dh_r, 16'd0} - {6'd0, p});
  assign upd     = cmd.init || (w < key_q);
  assign new_key = upd ? w : key_q;
  assign new_len = upd ? root_r : key_q_r[95:64];
  assign new_h   = upd ? dh_r : key_q_r[119:96];

  // saturating weight sum
  assign s65 = {sum_w_r[63], sum_w_r} + {min_key_r[63], min_key_r};
  always_comb begin
    if (s65[64] != s65[63]) begin
      sat_sum = s65[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      sat_sum = s65[63:0];
    end
  end

  assign mag = sum_w_r[63] ? (~sum_w_r + 64'd1) : sum_w_r;
  assign r2  = {drem_r[47:0], dd_r[70]};

  assign sts.in_tree = key_q_r[120];
  assign sts.conv    = (mag <= {48'd0, tolerance});
  assign rate        = rate_r;
  assign rate_sat    = sat_r;

  always_ff @(posedge clk) begin
    if (cmd.pt_wr) begin
      pt_mem[cmd.wr_addr] <= {in_x, in_y, in_h};
    end
    if (cmd.rd) begin
      pt_q_r   <= pt_mem[raddr];
      key_q_r  <= key_mem[raddr];
      rd_idx_r <= raddr;
    end
    if (cmd.edge_fin && upd) begin
      key_mem[rd_idx_r] <= {1'b0, dh_r, root_r, w};
    end else if (cmd.mark) begin
      key_mem[pick_r] <= {1'b1, min_h_r, min_len_r, min_key_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.from_ld) begin
      px_r <= xq;
      py_r <= yq;
      ph_r <= hq;
    end
    if (cmd.sq_mul) begin
      sqx_r <= dx * dx;
      sqy_r <= dy * dy;
      dh_r  <= (ph_r > hq) ? ph_r - hq : hq - ph_r;
    end
    if (cmd.sqrt_ld) begin
      v_r    <= {1'b0, {1'b0, sqx_r} + {1'b0, sqy_r}, 30'd0};
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      v_r <= {v_r[61:0], 2'b00};
      if (srem >= strial) begin
        rem_r  <= srem - strial;
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= srem;
        root_r <= {root_r[30:0], 1'b0};
      end
    end
    if (cmd.mul_w) begin
      m_hi_r <= rate_r * root_r[31:16];
      m_lo_r <= rate_r * root_r[15:0];
    end
    if (cmd.edge_fin && (!found_r || new_key < min_key_r)) begin
      min_key_r <= new_key;
      min_len_r <= new_len;
      min_h_r   <= new_h;
      pick_r    <= rd_idx_r;
    end
    if (cmd.sums_clr) begin
      sum_w_r <= '0;
      sum_l_r <= '0;
      sum_h_r <= '0;
    end else if (cmd.sums_acc) begin
      sum_w_r <= sat_sum;
      sum_l_r <= sum_l_r + {16'd0, min_len_r};
      sum_h_r <= sum_h_r + {16'd0, min_h_r};
    end
    if (cmd.div_ld) begin
      dd_r   <= {sum_h_r, 31'd0};
      drem_r <= '0;
      q_r    <= '0;
    end else if (cmd.div_step) begin
      dd_r <= {dd_r[69:0], 1'b0};
      if (r2 >= {1'b0, sum_l_r}) begin
        drem_r <= r2 - {1'b0, sum_l_r};
        q_r    <= {q_r[69:0], 1'b1};
      end else begin
        drem_r <= r2;
        q_r    <= {q_r[69:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      rate_r  <= mrst_pkg::RATE_ONE;
      sat_r   <= 1'b0;
    end else begin
      if (cmd.min_clr) begin
        found_r <= 1'b0;
      end else if (cmd.edge_fin) begin
        found_r <= 1'b1;
      end
      if (cmd.rate_one) begin
        rate_r <= mrst_pkg::RATE_ONE;
        sat_r  <= 1'b0;
      end else if (cmd.rate_upd) begin
        if (sum_l_r == '0 || q_r[70:40] != '0) begin
          rate_r <= mrst_pkg::RATIO_MAX;
          sat_r  <= 1'b1;
        end else begin
          rate_r <= q_r[39:0];
          sat_r  <= 1'b0;
        end
      end
    end
  end

endmodule

[hw/rtl/mrst_ctrl.sv]
module mrst_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tlast,
  output logic                          in_tready,
  input  logic                          out_busy,
  output logic                          out_load,
  input  logic [mrst_pkg::ROUND_W-1:0]  iter_limit,
  input  mrst_pkg::mrst_sts_t           sts,
  output mrst_pkg::mrst_cmd_t           cmd,
  output logic [mrst_pkg::ROUND_W-1:0]  rounds,
  output logic                          conv
);

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_RSTART = 4'd1;
  localparam logic [3:0] S_FROM   = 4'd2;
  localparam logic [3:0] S_FROM2  = 4'd3;
  localparam logic [3:0] S_RD     = 4'd4;
  localparam logic [3:0] S_RD2    = 4'd5;
  localparam logic [3:0] S_SQ1    = 4'd6;
  localparam logic [3:0] S_SQ     = 4'd7;
  localparam logic [3:0] S_W1     = 4'd8;
  localparam logic [3:0] S_W2     = 4'd9;
  localparam logic [3:0] S_MARK   = 4'd10;
  localparam logic [3:0] S_REND   = 4'd11;
  localparam logic [3:0] S_DIV    = 4'd12;
  localparam logic [3:0] S_RUPD   = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  logic [3:0]                   state_r, state_nxt;
  logic [mrst_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [mrst_pkg::CNT_W-1:0]   j_r, j_nxt;
  logic [mrst_pkg::CNT_W-1:0]   step_r, step_nxt;
  logic [mrst_pkg::STEP_W-1:0]  cnt_r, cnt_nxt;
  logic [mrst_pkg::ROUND_W-1:0] rounds_r, rounds_nxt;
  logic                         init_r, init_nxt;
  logic                         conv_r, conv_nxt;
  logic [mrst_pkg::CNT_W-1:0]   last_idx;
  logic [mrst_pkg::ROUND_W-1:0] limit;

  assign last_idx = count_r - mrst_pkg::CNT_W'(1);
  assign limit    = (iter_limit == '0) ? mrst_pkg::ROUND_W'(1) : iter_limit;
  assign rounds   = rounds_r;
  assign conv     = conv_r;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    j_nxt      = j_r;
    step_nxt   = step_r;
    cnt_nxt    = cnt_r;
    rounds_nxt = rounds_r;
    init_nxt   = init_r;
    conv_nxt   = conv_r;
    cmd        = '0;
    cmd.wr_addr = count_r[mrst_pkg::IDX_W-1:0];
    cmd.rd_addr = j_r[mrst_pkg::IDX_W-1:0];
    cmd.init    = init_r;
    in_tready  = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (count_r < mrst_pkg::CNT_W'(mrst_pkg::MAX_POINTS)) begin
            cmd.pt_wr = 1'b1;
            count_nxt = count_r + mrst_pkg::CNT_W'(1);
          end
          if (in_tlast) begin
            cmd.rate_one = 1'b1;
            rounds_nxt   = '0;
            state_nxt    = S_RSTART;
          end
        end
      end
      S_RSTART: begin
        cmd.sums_clr = 1'b1;
        rounds_nxt   = rounds_r + mrst_pkg::ROUND_W'(1);
        step_nxt     = '0;
        init_nxt     = 1'b1;
        state_nxt    = (count_r >= mrst_pkg::CNT_W'(2)) ? S_FROM : S_REND;
      end
      S_FROM: begin
        cmd.rd      = 1'b1;
        cmd.rd_pick = !init_r;
        cmd.rd_addr = '0;
        state_nxt   = S_FROM2;
      end
      S_FROM2: begin
        cmd.from_ld = 1'b1;
        cmd.min_clr = 1'b1;
        j_nxt       = mrst_pkg::CNT_W'(1);
        state_nxt   = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        if (sts.in_tree && !init_r) begin
          if (j_r == last_idx) begin
            state_nxt = S_MARK;
          end else begin
            j_nxt     = j_r + mrst_pkg::CNT_W'(1);
            state_nxt = S_RD;
          end
        end else begin
          cmd.sq_mul = 1'b1;
          state_nxt  = S_SQ1;
        end
      end
      S_SQ1: begin
        cmd.sqrt_ld = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_SQ;
      end
      S_SQ: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + mrst_pkg::STEP_W'(1);
        if (cnt_r == mrst_pkg::STEP_W'(mrst_pkg::SQRT_STEPS - 1)) begin
          state_nxt = S_W1;
        end
      end
      S_W1: begin
        cmd.mul_w = 1'b1;
        state_nxt = S_W2;
      end
      S_W2: begin
        cmd.edge_fin = 1'b1;
        if (j_r == last_idx) begin
          state_nxt = S_MARK;
        end else begin
          j_nxt     = j_r + mrst_pkg::CNT_W'(1);
          state_nxt = S_RD;
        end
      end
      S_MARK: begin
        cmd.mark     = 1'b1;
        cmd.sums_acc = 1'b1;
        step_nxt     = step_r + mrst_pkg::CNT_W'(1);
        init_nxt     = 1'b0;
        state_nxt    = (step_nxt == last_idx) ? S_REND : S_FROM;
      end
      S_REND: begin
        if (sts.conv) begin
          conv_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.div_ld = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + mrst_pkg::STEP_W'(1);
        if (cnt_r == mrst_pkg::STEP_W'(mrst_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_RUPD;
        end
      end
      S_RUPD: begin
        cmd.rate_upd = 1'b1;
        if (rounds_r >= limit) begin
          conv_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RSTART;
        end
      end
      S_DONE: begin
        if (!out_busy) begin
          out_load  = 1'b1;
          count_nxt = '0;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      count_r  <= '0;
      j_r      <= '0;
      step_r   <= '0;
      cnt_r    <= '0;
      rounds_r <= '0;
      init_r   <= 1'b1;
      conv_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      j_r      <= j_nxt;
      step_r   <= step_nxt;
      cnt_r    <= cnt_nxt;
      rounds_r <= rounds_nxt;
      init_r   <= init_nxt;
      conv_r   <= conv_nxt;
    end
  end

endmodule

[hw/rtl/min_ratio_spanning_tree_core.sv]
// Channel  Dir  Beat contents
// in_      in   tdata: point_x, point_y, point_height; tlast: last_point
// out_     out  tdata: best_ratio, rounds_used; tuser: converged, ratio_saturated
// cfg_     in   write only: index 0 tolerance, index 1 iteration_limit
//
// Points load one beat per cycle into the point store. After the last beat each
// round takes a setup step plus n-1 sweeps. A sweep takes the square root and weight
// of each point still outside the tree; after the first sweep it only reads a point
// already in it. A round that misses tolerance goes on to a rate divide and update.
// No input beat is taken during the solve. Reset clears controller, configuration
// registers, rate and output valid; the stores need no clear. A waiting result stalls
// only the next result, not loading.
module min_ratio_spanning_tree_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // [15:0] point_x, [31:16] point_y, [55:32] point_height
  input  logic        in_tlast,   // last_point
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [39:0] best_ratio, [47:40] rounds_used
  output logic [1:0]  out_tuser,  // [0] converged, [1] ratio_saturated
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  mrst_pkg::mrst_cmd_t cmd;
  mrst_pkg::mrst_sts_t sts;

  logic [mrst_pkg::TOL_W-1:0]   tol_r;
  logic [mrst_pkg::ROUND_W-1:0] lim_r;
  logic [mrst_pkg::RATE_W-1:0]  rate;
  logic                         rate_sat;
  logic [mrst_pkg::ROUND_W-1:0] rounds;
  logic                         conv;
  logic                         out_load;
  logic                         out_valid_r;
  logic [47:0]                  out_data_r;
  logic [1:0]                   out_user_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= mrst_pkg::TOL_W'(1);
      lim_r <= mrst_pkg::ROUND_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        mrst_pkg::REG_TOLERANCE:  tol_r <= cfg_wdata;
        mrst_pkg::REG_ITER_LIMIT: lim_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  mrst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_busy   (out_valid_r && !out_tready),
    .out_load   (out_load),
    .iter_limit (lim_r),
    .sts        (sts),
    .cmd        (cmd),
    .rounds     (rounds),
    .conv       (conv)
  );

  mrst_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_x      (in_tdata[15:0]),
    .in_y      (in_tdata[31:16]),
    .in_h      (in_tdata[55:32]),
    .tolerance (tol_r),
    .sts       (sts),
    .rate      (rate),
    .rate_sat  (rate_sat)
  );

  // result register: one beat per solved set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {rounds, rate};
      out_user_r <= {rate_sat, conv};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

[hw/rtl/mrst_checker.sv]
`include "min_ratio_spanning_tree_core_assert.svh"

module mrst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  `MRST_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result beat dropped")
  `MRST_ASSERT_NXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata), "stalled result changed")
  `MRST_ASSERT_NXT(a_solve_starts, clk, rst_n, in_tvalid && in_tready && in_tlast, !in_tready, "input taken during solve")
  `MRST_ASSERT_IMP(a_rounds_nz, clk, rst_n, out_tvalid, out_tdata[47:40] != 8'd0, "result with no rounds")

endmodule

bind min_ratio_spanning_tree_core mrst_checker u_mrst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
